@@ hw/rtl/lkvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache.
`default_nettype none
package lkvc_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic found;
        logic old_found;
        logic free_found;
    } t_scan_flags;

endpackage
`default_nettype wire

@@ hw/rtl/lkvc_if.sv @@
// Request and response channel interfaces of the LRU key/value cache.
`default_nettype none
interface lkvc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [lkvc_pkg::KEY_W-1:0]  lookup_key;
    logic [lkvc_pkg::DATA_W-1:0] store_value;

    modport source (output valid, output req_type, output lookup_key, output store_value,
                    input ready);
    modport sink (input valid, input req_type, input lookup_key, input store_value,
                  output ready);
endinterface

interface lkvc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [lkvc_pkg::DATA_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink (input valid, input hit, input read_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/lkvc_scan_unit.sv @@
// Per-entry scan step: key match, oldest entry and first free slot accumulators.
`default_nettype none
module lkvc_scan_unit #(
    parameter int IDX_W = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_step,
    input  logic [lkvc_pkg::KEY_W-1:0]  i_key,
    input  logic                        i_ent_valid,
    input  logic [lkvc_pkg::KEY_W-1:0]  i_ent_key,
    input  logic [lkvc_pkg::DATA_W-1:0] i_ent_data,
    input  logic [IDX_W-1:0]            i_ent_rank,
    input  logic [IDX_W-1:0]            i_ent_idx,
    output lkvc_pkg::t_scan_flags       o_flags,
    output logic [IDX_W-1:0]            o_found_idx,
    output logic [lkvc_pkg::DATA_W-1:0] o_found_data,
    output logic [IDX_W-1:0]            o_found_rank,
    output logic [IDX_W-1:0]            o_old_idx,
    output logic [IDX_W-1:0]            o_free_idx
);
    import lkvc_pkg::*;

    t_scan_flags         r_flags;
    logic [IDX_W-1:0]    r_found_idx;
    logic [DATA_W-1:0]   r_found_data;
    logic [IDX_W-1:0]    r_found_rank;
    logic [IDX_W-1:0]    r_old_idx;
    logic [IDX_W-1:0]    r_old_rank;
    logic [IDX_W-1:0]    r_free_idx;

    logic is_match;
    logic is_older;
    logic is_free;

    always_comb begin
        is_match = i_ent_valid && (i_ent_key == i_key) && !r_flags.found;
        is_older = i_ent_valid && (!r_flags.old_found || (i_ent_rank > r_old_rank));
        is_free  = !i_ent_valid && !r_flags.free_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_clear) begin
            r_flags <= '0;
        end else if (i_step) begin
            if (is_match) begin
                r_flags.found <= 1'b1;
            end
            if (is_older) begin
                r_flags.old_found <= 1'b1;
            end
            if (is_free) begin
                r_flags.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (is_match) begin
                r_found_idx  <= i_ent_idx;
                r_found_data <= i_ent_data;
                r_found_rank <= i_ent_rank;
            end
            if (is_older) begin
                r_old_idx  <= i_ent_idx;
                r_old_rank <= i_ent_rank;
            end
            if (is_free) begin
                r_free_idx <= i_ent_idx;
            end
        end
    end

    assign o_flags      = r_flags;
    assign o_found_idx  = r_found_idx;
    assign o_found_data = r_found_data;
    assign o_found_rank = r_found_rank;
    assign o_old_idx    = r_old_idx;
    assign o_free_idx   = r_free_idx;

endmodule
`default_nettype wire

@@ hw/rtl/lru_key_value_cache_unit.sv @@
// Top level of the fully associative LRU key/value cache.
// Usage:
//   i_req carries items {req_type, lookup_key, store_value}; req_type get looks a key up,
//   put inserts or updates it. o_rsp carries {hit, read_value} for each get only;
//   read_value is zero on a miss. A put gives no response item.
//   i_cfg_we/i_cfg_wdata write the capacity (0 acts as 1, above MAX_ENTRIES saturates);
//   write it only while the block is idle.
// Timing:
//   One item at a time. An accepted item scans all MAX_ENTRIES entries through the key
//   and data memory read port, one entry per cycle as set by the single read port of
//   the entry memories, then applies its update to the entries and recency ranks.
// Reset:
//   Synchronous, active low. Empties the cache and sets capacity to 16; no clearing pass.
// Backpressure:
//   The response sits in an output register; the next item is taken while it waits.
//   A get that finishes while that register is still full holds its update until the
//   receiver takes the earlier response.
`default_nettype none
module lru_key_value_cache_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0] i_cfg_wdata,
    lkvc_req_if.sink                   i_req,
    lkvc_rsp_if.source                 o_rsp
);
    import lkvc_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    t_state r_state;
    t_state n_state;

    logic [CAP_W-1:0]  r_cap;
    logic              r_type;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_val;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_stg_vld;
    logic [IDX_W-1:0]  r_stg_idx;

    logic [KEY_W-1:0]  r_mem_key [MAX_ENTRIES];
    logic [DATA_W-1:0] r_mem_data [MAX_ENTRIES];
    logic [KEY_W-1:0]  r_key_q;
    logic [DATA_W-1:0] r_data_q;

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [MAX_ENTRIES-1:0] n_valid;
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];
    logic [IDX_W-1:0]       n_rank [MAX_ENTRIES];
    logic [CNT_W-1:0]       r_occ;
    logic [CNT_W-1:0]       n_occ;

    logic              r_out_vld;
    logic              r_out_hit;
    logic [DATA_W-1:0] r_out_data;

    t_scan_flags       scan_flags;
    logic [IDX_W-1:0]  found_idx;
    logic [DATA_W-1:0] found_data;
    logic [IDX_W-1:0]  found_rank;
    logic [IDX_W-1:0]  old_idx;
    logic [IDX_W-1:0]  free_idx;

    logic             req_ready;
    logic             req_fire;
    logic             scan_issue;
    logic             scan_last;
    logic [IDX_W-1:0] rd_addr;
    logic             do_apply;
    logic [CNT_W-1:0] eff_cap;
    logic             evict;
    logic             slot_ok;
    logic [IDX_W-1:0] slot;
    logic             keep;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (do_apply) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        req_ready  = 1'b0;
        scan_issue = 1'b0;
        do_apply   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                req_ready = 1'b1;
            end
            ST_SCAN: begin
                scan_issue = !scan_last;
            end
            ST_APPLY: begin
                do_apply = (r_type == REQ_PUT) || !r_out_vld || o_rsp.ready;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = req_ready;
    assign req_fire    = i_req.valid && req_ready;
    assign scan_last   = (r_cnt == CNT_W'(MAX_ENTRIES));
    assign rd_addr     = r_cnt[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cap     <= CAP_RESET;
            r_cnt     <= '0;
            r_stg_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_stg_vld <= scan_issue;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (req_fire) begin
                r_cnt <= '0;
            end else if (scan_issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (do_apply && (r_type == REQ_GET)) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_type <= i_req.req_type;
            r_key  <= i_req.lookup_key;
            r_val  <= i_req.store_value;
        end
        if (scan_issue) begin
            r_stg_idx <= rd_addr;
        end
        if (do_apply && (r_type == REQ_GET)) begin
            r_out_hit  <= scan_flags.found;
            r_out_data <= scan_flags.found ? found_data : '0;
        end
    end

    // Entry memories: one read and one write port each
    always_ff @(posedge i_clk) begin
        r_key_q  <= r_mem_key[rd_addr];
        r_data_q <= r_mem_data[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (do_apply && (r_type == REQ_PUT)) begin
            if (scan_flags.found) begin
                r_mem_data[found_idx] <= r_val;
            end else if (slot_ok) begin
                r_mem_key[slot]  <= r_key;
                r_mem_data[slot] <= r_val;
            end
        end
    end

    lkvc_scan_unit #(
        .IDX_W (IDX_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (req_fire),
        .i_step       (r_stg_vld),
        .i_key        (r_key),
        .i_ent_valid  (r_valid[r_stg_idx]),
        .i_ent_key    (r_key_q),
        .i_ent_data   (r_data_q),
        .i_ent_rank   (r_rank[r_stg_idx]),
        .i_ent_idx    (r_stg_idx),
        .o_flags      (scan_flags),
        .o_found_idx  (found_idx),
        .o_found_data (found_data),
        .o_found_rank (found_rank),
        .o_old_idx    (old_idx),
        .o_free_idx   (free_idx)
    );

    // Effective capacity and insert slot
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CNT_W'(1);
        end else if (int'(r_cap) > MAX_ENTRIES) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(r_cap);
        end
        evict = (r_occ >= eff_cap) && scan_flags.old_found;
        if (evict && (!scan_flags.free_found || (old_idx < free_idx))) begin
            slot    = old_idx;
            slot_ok = 1'b1;
        end else begin
            slot    = free_idx;
            slot_ok = scan_flags.free_found;
        end
    end

    // Recency update
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        n_occ   = r_occ;
        keep    = 1'b0;
        if (do_apply && scan_flags.found) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (r_valid[i] && (r_rank[i] < found_rank)) begin
                    n_rank[i] = r_rank[i] + 1'b1;
                end
            end
            n_rank[found_idx] = '0;
        end else if (do_apply && (r_type == REQ_PUT)) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                keep       = r_valid[i] && !(evict && (IDX_W'(i) == old_idx));
                n_valid[i] = keep;
                n_rank[i]  = keep ? r_rank[i] + 1'b1 : '0;
            end
            if (slot_ok) begin
                n_valid[slot] = 1'b1;
                n_rank[slot]  = '0;
            end
            n_occ = r_occ - CNT_W'(evict) + CNT_W'(slot_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_rank  <= n_rank;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_data;

`ifndef NO_ASSERTIONS
    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_occ))
        else $error("occupancy differs from valid entry count");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_occ) <= MAX_ENTRIES)
        else $error("occupancy above entry count");

    a_rsp_from_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(do_apply && (r_type == REQ_GET)))
        else $error("response without a finished get");

    a_scan_to_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && scan_last) |=> (r_state == ST_APPLY))
        else $error("scan end did not enter update");
`endif

endmodule
`default_nettype wire
